[rtl/nbli_pkg.sv]
package nbli_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_QUERY  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FEW     = 2'd1;
	localparam logic [1:0] ST_ZERO_DX = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam int DVD_W = 64;
	localparam int DSR_W = 32;

	typedef struct packed {
		logic        [1:0]  op;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_x;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_y;
		logic        [1:0]  status;
	} rsp_t;

	typedef enum logic [1:0] {
		KIND_CLEAR  = 2'd0,
		KIND_APPEND = 2'd1,
		KIND_QUERY  = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// x carries point_x for appends and query_x for queries
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] x;
		logic signed [31:0] y;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_if_t;

endpackage

[rtl/nbli_front.sv]
module nbli_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  nbli_pkg::req_t   req,
	output nbli_pkg::cmd_if_t cq,
	input  logic             pop
);

	nbli_pkg::cmd_t slot_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	nbli_pkg::cmd_t cmd_in;
	logic           push;

	// decode op into a command kind
	always_comb begin
		cmd_in.x = req.point_x;
		cmd_in.y = req.point_y;
		case (req.op)
			nbli_pkg::OP_CLEAR:  cmd_in.kind = nbli_pkg::KIND_CLEAR;
			nbli_pkg::OP_APPEND: cmd_in.kind = nbli_pkg::KIND_APPEND;
			nbli_pkg::OP_QUERY: begin
				cmd_in.kind = nbli_pkg::KIND_QUERY;
				cmd_in.x    = req.query_x;
			end
			default:             cmd_in.kind = nbli_pkg::KIND_NONE;
		endcase
	end

	assign req_ready = (cnt_q != 2'd2);
	assign push      = req_valid && req_ready;
	assign cq.valid  = (cnt_q != 2'd0);
	assign cq.cmd    = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= cmd_in;
	end

endmodule

[rtl/nbli_div.sv]
module nbli_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [nbli_pkg::DVD_W-1:0]    dividend,
	input  logic [nbli_pkg::DSR_W-1:0]    divisor,
	output logic                          done,
	output logic [nbli_pkg::DVD_W-1:0]    quotient
);

	localparam int CNT_W = $clog2(nbli_pkg::DVD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [nbli_pkg::DVD_W-1:0]  dvd_q;
	logic [nbli_pkg::DSR_W-1:0]  dsr_q;
	logic [nbli_pkg::DSR_W-1:0]  rem_q;
	logic [nbli_pkg::DSR_W:0]    rem_sh;
	logic [nbli_pkg::DSR_W:0]    rem_sub;
	logic                        ge;

	// restoring, one quotient bit per cycle; quotient bits shift into dvd_q
	assign rem_sh  = {rem_q, dvd_q[nbli_pkg::DVD_W-1]};
	assign ge      = (rem_sh >= {1'b0, dsr_q});
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	assign done     = done_q;
	assign quotient = dvd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(nbli_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[nbli_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[nbli_pkg::DSR_W-1:0] : rem_sh[nbli_pkg::DSR_W-1:0];
		end
	end

endmodule

[rtl/nbli_back.sv]
module nbli_back #(
	parameter int TABLE_DEPTH = nbli_pkg::DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  nbli_pkg::cmd_if_t cq,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output nbli_pkg::rsp_t    rsp
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [9:0] {
		S_IDLE = 10'b00_0000_0001,
		S_SCAN = 10'b00_0000_0010,
		S_SEL  = 10'b00_0000_0100,
		S_RDA  = 10'b00_0000_1000,
		S_RDB  = 10'b00_0001_0000,
		S_RDC  = 10'b00_0010_0000,
		S_RDD  = 10'b00_0100_0000,
		S_MUL  = 10'b00_1000_0000,
		S_DIV  = 10'b01_0000_0000,
		S_FIN  = 10'b10_0000_0000
	} state_t;

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] t;
		t = v[32] ? 33'(-v) : 33'(v);
		return t[31:0];
	endfunction

	logic signed [31:0] x_mem [TABLE_DEPTH];
	logic signed [31:0] y_mem [TABLE_DEPTH];
	logic signed [31:0] rd_x_q;
	logic signed [31:0] rd_y_q;
	logic [AW-1:0]      rd_addr;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      scan_i_q;
	logic               scan_v_q;
	logic [AW-1:0]      scan_di_q;
	logic               rsp_valid_q;
	nbli_pkg::rsp_t     rsp_q;
	nbli_pkg::rsp_t     res_q;
	nbli_pkg::rsp_t     idle_rsp;

	logic signed [31:0] q_q;
	logic [32:0]        best_q;
	logic signed [31:0] best_x_q;
	logic [AW-1:0]      idx_q;
	logic [AW-1:0]      lo_q;
	logic [AW-1:0]      hi_q;
	logic signed [32:0] off_q;
	logic signed [31:0] xl_q;
	logic signed [31:0] yl_q;
	logic signed [32:0] dx_q;
	logic signed [32:0] dy_q;
	logic signed [31:0] yidx_q;
	logic               neg_q;

	logic               free;
	logic               full;
	logic               run_query;
	logic               ld_idle;
	logic               rsp_load;
	logic [31:0]        scan_d;
	logic               last_idx;
	logic               div_start;
	logic               div_done;
	logic [63:0]        div_quo;
	logic [63:0]        product;
	logic [34:0]        quo_c;
	logic signed [34:0] sum;
	logic signed [31:0] sat;

	assign free      = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == CW'(TABLE_DEPTH));
	assign pop       = (state_q == S_IDLE) && cq.valid && free;
	assign run_query = (cq.cmd.kind == nbli_pkg::KIND_QUERY) && (count_q >= CW'(2));
	assign ld_idle   = pop && !run_query;
	assign rsp_load  = ld_idle || ((state_q == S_FIN) && free);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		idle_rsp.value_y = '0;
		idle_rsp.status  = nbli_pkg::ST_OK;
		case (cq.cmd.kind)
			nbli_pkg::KIND_APPEND: if (full) idle_rsp.status = nbli_pkg::ST_FULL;
			nbli_pkg::KIND_QUERY:  idle_rsp.status = nbli_pkg::ST_FEW;
			default:               idle_rsp.status = nbli_pkg::ST_OK;
		endcase
	end

	// one read address per cycle, shared by the scan and the segment reads
	always_comb begin
		case (state_q)
			S_SCAN:  rd_addr = scan_i_q[AW-1:0];
			S_RDA:   rd_addr = lo_q;
			S_RDB:   rd_addr = hi_q;
			S_RDC:   rd_addr = idx_q;
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop && cq.cmd.kind == nbli_pkg::KIND_APPEND && !full) begin
			x_mem[count_q[AW-1:0]] <= cq.cmd.x;
			y_mem[count_q[AW-1:0]] <= cq.cmd.y;
		end
		rd_x_q <= x_mem[rd_addr];
		rd_y_q <= y_mem[rd_addr];
	end

	assign scan_d   = mag33(33'({q_q[31], q_q}) - 33'({rd_x_q[31], rd_x_q}));
	assign last_idx = (CW'(idx_q) == count_q - CW'(1));

	assign div_start = (state_q == S_MUL) && (dx_q != '0);
	assign product   = 64'(mag33(off_q)) * 64'(mag33(dy_q));

	nbli_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product),
		.divisor  (mag33(dx_q)),
		.done     (div_done),
		.quotient (div_quo)
	);

	// clamp big quotients; anything past 2^33 saturates the same way
	assign quo_c = (div_quo > 64'h2_0000_0000) ? 35'h2_0000_0001 : div_quo[34:0];
	assign sum   = 35'({{3{yidx_q[31]}}, yidx_q}) + (neg_q ? 35'(-quo_c) : quo_c);
	always_comb begin
		if (sum > 35'sd2147483647)       sat = 32'sh7FFF_FFFF;
		else if (sum < -35'sd2147483648) sat = 32'sh8000_0000;
		else                             sat = sum[31:0];
	end

	// response valid: set on a load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)       rsp_valid_q <= 1'b1;
			else if (rsp_ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			scan_i_q    <= '0;
			scan_v_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						case (cq.cmd.kind)
							nbli_pkg::KIND_CLEAR:  count_q <= '0;
							nbli_pkg::KIND_APPEND: if (!full) count_q <= count_q + CW'(1);
							default:               count_q <= count_q;
						endcase
						if (run_query) begin
							state_q  <= S_SCAN;
							scan_i_q <= '0;
							scan_v_q <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (scan_i_q != count_q) begin
						scan_i_q <= scan_i_q + CW'(1);
						scan_v_q <= 1'b1;
					end else begin
						scan_v_q <= 1'b0;
						if (!scan_v_q) state_q <= S_SEL;
					end
				end
				S_SEL: state_q <= S_RDA;
				S_RDA: state_q <= S_RDB;
				S_RDB: state_q <= S_RDC;
				S_RDC: state_q <= S_RDD;
				S_RDD: state_q <= S_MUL;
				S_MUL: state_q <= (dx_q == '0) ? S_FIN : S_DIV;
				S_DIV: if (div_done) state_q <= S_FIN;
				S_FIN: if (free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ld_idle) rsp_q <= idle_rsp;
		if (state_q == S_FIN && free) rsp_q <= res_q;
		case (state_q)
			S_IDLE: begin
				q_q    <= cq.cmd.x;
				best_q <= '1;
			end
			S_SCAN: begin
				scan_di_q <= scan_i_q[AW-1:0];
				// ties go to the later index
				if (scan_v_q && {1'b0, scan_d} <= best_q) begin
					best_q   <= {1'b0, scan_d};
					best_x_q <= rd_x_q;
					idx_q    <= scan_di_q;
				end
			end
			S_SEL: begin
				off_q <= 33'({q_q[31], q_q}) - 33'({best_x_q[31], best_x_q});
				if (best_x_q > q_q) begin
					if (idx_q != '0) begin
						lo_q <= idx_q - AW'(1);
						hi_q <= idx_q;
					end else begin
						lo_q <= '0;
						hi_q <= AW'(1);
					end
				end else begin
					if (!last_idx) begin
						lo_q <= idx_q;
						hi_q <= idx_q + AW'(1);
					end else begin
						lo_q <= idx_q - AW'(1);
						hi_q <= idx_q;
					end
				end
			end
			S_RDB: begin
				xl_q <= rd_x_q;
				yl_q <= rd_y_q;
			end
			S_RDC: begin
				dx_q <= 33'({rd_x_q[31], rd_x_q}) - 33'({xl_q[31], xl_q});
				dy_q <= 33'({rd_y_q[31], rd_y_q}) - 33'({yl_q[31], yl_q});
			end
			S_RDD: yidx_q <= rd_y_q;
			S_MUL: begin
				neg_q <= (off_q[32] ^ dy_q[32] ^ dx_q[32]) && (off_q != '0) && (dy_q != '0);
				res_q.value_y <= '0;
				res_q.status  <= nbli_pkg::ST_ZERO_DX;
			end
			S_DIV: begin
				if (div_done) begin
					res_q.value_y <= sat;
					res_q.status  <= nbli_pkg::ST_OK;
				end
			end
			default: ;
		endcase
	end

endmodule

[rtl/nearest_bracket_linear_interp_unit.sv]
// Piecewise linear interpolation over an unsorted table of up to TABLE_DEPTH
// (x, y) points in signed Q16.16. Each request transaction clears the table,
// appends a point, queries one x or does nothing (unused op), and yields
// exactly one response transaction carrying value_y and status (ok, fewer
// than two points, zero dx, table full). A query finds the nearest stored x
// (ties to the later entry), picks the neighboring segment, and returns
// y_idx + (q - x_idx)*dy/dx rounded toward zero and saturated. Requests land
// in a two-entry queue, so up to two can be taken while the core is busy.
// With the core idle and the response side free, clear, append, no-op and
// short queries raise the response after passing through the queue slot and
// the response register. A query first scans the stored points through the
// table's single read port, then does the segment reads and setup, runs
// the bit-serial divider and loads the response. A zero-dx query skips the
// divider. No clearing pass after reset.
module nearest_bracket_linear_interp_unit #(
	parameter int TABLE_DEPTH = nbli_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  nbli_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output nbli_pkg::rsp_t rsp
);

	nbli_pkg::cmd_if_t cq;   // head of the request queue
	logic              pop;  // back end takes the head transaction

	// front: op decode and two-entry queue
	nbli_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cq        (cq),
		.pop       (pop)
	);

	// back: point table, nearest scan, divider and response register
	nbli_back #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cq        (cq),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

[rtl/nbli_checker.sv]
module nbli_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input nbli_pkg::rsp_t rsp
);

	logic [2:0] open_q;
	logic       req_acc;
	logic       rsp_acc;

	assign req_acc = req_valid && req_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + 3'(req_acc) - 3'(rsp_acc);
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_rsp_has_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> open_q != 3'd0)
		else $error("response without an open request");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= 3'd4)
		else $error("too many open transactions");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != nbli_pkg::ST_OK |-> rsp.value_y == '0)
		else $error("error response with nonzero value");

endmodule

bind nearest_bracket_linear_interp_unit nbli_checker u_chk (.*);

[verif/tb_nearest_bracket_linear_interp_unit.sv]
module tb_nearest_bracket_linear_interp_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH = 64;
	localparam int RANDOM_ITEMS = 800;
	localparam int IDLE_LIMIT = 4000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	nbli_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready;
	nbli_pkg::rsp_t rsp;

	nearest_bracket_linear_interp_unit #(
		.TABLE_DEPTH(TBL_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Predictor shadow of the point table. Only entries below pt_count are
	// ever read, so stale contents beyond it never matter.
	logic signed [31:0] x_tab [TBL_DEPTH];
	logic signed [31:0] y_tab [TBL_DEPTH];
	int unsigned pt_count;

	nbli_pkg::rsp_t interp_expected [$];
	int unsigned err_count;
	bit quiet_phase;      // no idling on either side near the end
	int unsigned idle_cycles;
	int unsigned stall_left;

	task automatic report_mismatch(input string what, input logic [33:0] got,
			input logic [33:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		err_count++;
	endtask

	function automatic logic [63:0] abs64(input logic signed [63:0] v);
		return v < 0 ? -v : v;
	endfunction

	// Nearest-sample bracketing interpolation, updates the shadow table too.
	function automatic nbli_pkg::rsp_t interp_predict(input nbli_pkg::req_t r);
		nbli_pkg::rsp_t o;
		logic signed [63:0] q, dx, dy, off, sum;
		logic [63:0] best, d, prod, quo;
		int unsigned idx, lo, hi;
		bit neg;
		o = '0;
		o.status = nbli_pkg::ST_OK;
		case (r.op)
			nbli_pkg::OP_CLEAR: begin
				pt_count = 0;
			end
			nbli_pkg::OP_APPEND: begin
				if (pt_count >= TBL_DEPTH) begin
					o.status = nbli_pkg::ST_FULL;
				end else begin
					x_tab[pt_count] = r.point_x;
					y_tab[pt_count] = r.point_y;
					pt_count++;
				end
			end
			nbli_pkg::OP_QUERY: begin
				if (pt_count < 2) begin
					o.status = nbli_pkg::ST_FEW;
					return o;
				end
				q = r.query_x;
				best = '1;
				idx = 0;
				for (int i = 0; i < pt_count; i++) begin
					d = abs64(q - 64'(x_tab[i]));
					if (d <= best) begin  // ties go to the later entry
						best = d;
						idx = i;
					end
				end
				if (64'(x_tab[idx]) > q) begin
					if (idx > 0) begin lo = idx - 1; hi = idx; end
					else begin lo = 0; hi = 1; end
				end else begin
					if (idx < pt_count - 1) begin lo = idx; hi = idx + 1; end
					else begin lo = idx - 1; hi = idx; end
				end
				dx = 64'(x_tab[hi]) - 64'(x_tab[lo]);
				dy = 64'(y_tab[hi]) - 64'(y_tab[lo]);
				if (dx == 0) begin
					o.status = nbli_pkg::ST_ZERO_DX;
					return o;
				end
				off = q - 64'(x_tab[idx]);
				prod = abs64(off) * abs64(dy);
				quo = prod / abs64(dx);
				neg = ((off < 0) != (dy < 0)) != (dx < 0);
				if (prod == 0) neg = 1'b0;
				if (quo > 64'h2_0000_0000) begin
					sum = neg ? -64'sd2147483648 : 64'sd2147483647;
				end else begin
					sum = 64'(y_tab[idx]) + (neg ? -$signed(quo) : $signed(quo));
					if (sum > 64'sd2147483647) sum = 64'sd2147483647;
					if (sum < -64'sd2147483648) sum = -64'sd2147483648;
				end
				o.value_y = sum[31:0];
			end
			default: ;  // unused op code: no state change
		endcase
		return o;
	endfunction

	// Drive one request transaction and wait for acceptance. Valid stays up
	// across back-to-back transactions when no gap is wanted.
	task automatic send_req(input nbli_pkg::req_t r);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 12);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!(req_valid && req_ready));
		interp_expected = {interp_expected, interp_predict(r)};
	endtask

	// Response side: random stall bursts, compare on acceptance.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (interp_expected.size() == 0) begin
					report_mismatch("unexpected response", rsp, '0);
				end else begin
					if (rsp.value_y !== interp_expected[0].value_y)
						report_mismatch("value_y", 34'(rsp.value_y),
							34'(interp_expected[0].value_y));
					if (rsp.status !== interp_expected[0].status)
						report_mismatch("status", 34'(rsp.status),
							34'(interp_expected[0].status));
					void'(interp_expected.pop_front());
				end
			end
			if (quiet_phase) begin
				rsp_ready <= 1'b1;
			end else if (!rsp_ready) begin
				if (stall_left == 0) rsp_ready <= 1'b1;
				else stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 9) == 0) begin
				rsp_ready <= 1'b0;
				stall_left <= $urandom_range(1, 12) - 1;
			end
		end
	end

	// Watchdog: counts cycles with no transaction on either channel.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("nearest_bracket_linear_interp_unit regression: fail");
			$finish;
		end
	end

	function automatic nbli_pkg::req_t mk(input logic [1:0] op, input logic [31:0] px,
			input logic [31:0] py, input logic [31:0] qx);
		nbli_pkg::req_t r;
		r.op = op;
		r.point_x = px;
		r.point_y = py;
		r.query_x = qx;
		return r;
	endfunction

	function automatic logic [31:0] rand_x();
		case ($urandom_range(0, 5))
			0: return $urandom;                                  // full range
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 12;
		endcase
	endfunction

	typedef struct {
		nbli_pkg::req_t r;
		bit             known;   // expected result typed in
		nbli_pkg::rsp_t want;
	} dir_row_t;

	dir_row_t dir_tbl [$];
	nbli_pkg::req_t tmp;
	int sent;
	int npts;
	int drain;

	initial begin
		err_count = 0;
		quiet_phase = 1'b0;
		idle_cycles = 0;
		pt_count = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty and one-point queries, extremes, zero dx,
		// end-of-table neighbor switch, saturation both ways, unused op.
		dir_tbl = '{
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 0), 1, '{32'sd0, nbli_pkg::ST_FEW}},
			'{mk(nbli_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0), 1,
				'{32'sd0, nbli_pkg::ST_OK}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF), 1, '{32'sd0, nbli_pkg::ST_FEW}},
			'{mk(nbli_pkg::OP_APPEND, 32'h8000_0000, 32'h7FFF_FFFF, 0), 1,
				'{32'sd0, nbli_pkg::ST_OK}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h8000_0000), 1,
				'{32'sd0, nbli_pkg::ST_ZERO_DX}},
			'{mk(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1,
				'{32'sd0, nbli_pkg::ST_OK}},
			'{mk(nbli_pkg::OP_CLEAR, 0, 0, 0), 1, '{32'sd0, nbli_pkg::ST_OK}},
			'{mk(nbli_pkg::OP_APPEND, 32'h8000_0000, 32'h8000_0000, 0), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h8000_0000), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 0), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_CLEAR, 0, 0, 0), 0, '{0, 0}},
			// steep segment: huge slope saturates high and low
			'{mk(nbli_pkg::OP_APPEND, 0, 32'h8000_0000, 0), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_APPEND, 1, 32'h7FFF_FFFF, 0), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h7FFF_FFFF), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h8000_0000), 0, '{0, 0}},
			// tie between two samples, descending x
			'{mk(nbli_pkg::OP_APPEND, -32'sd65536, 32'h0001_0000, 0), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, -32'sd32768), 0, '{0, 0}},
			'{mk(nbli_pkg::OP_QUERY, 0, 0, 32'h0000_8000), 0, '{0, 0}}
		};
		foreach (dir_tbl[i]) begin
			send_req(dir_tbl[i].r);
			if (dir_tbl[i].known && interp_expected[$] !== dir_tbl[i].want)
				report_mismatch("directed row", interp_expected[$], dir_tbl[i].want);
		end

		// Fill to full and append past it.
		send_req(mk(nbli_pkg::OP_CLEAR, 0, 0, 0));
		for (int i = 0; i < TBL_DEPTH + 2; i++)
			send_req(mk(nbli_pkg::OP_APPEND, rand_x(), $urandom, 0));
		send_req(mk(nbli_pkg::OP_QUERY, 0, 0, rand_x()));

		// Random: build tables (mostly small, sometimes past full) then query them, with noise mixed in.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			if (sent > RANDOM_ITEMS - 100) quiet_phase = 1'b1;
			send_req(mk(nbli_pkg::OP_CLEAR, 0, 0, 0));
			npts = $urandom_range(0, 9) == 0 ? $urandom_range(0, TBL_DEPTH + 1)
				: $urandom_range(0, 8);
			for (int i = 0; i < npts; i++) begin
				if ($urandom_range(0, 19) == 0)
					tmp = mk(OP_UNUSED, $urandom, $urandom, $urandom);
				else tmp = mk(nbli_pkg::OP_APPEND, rand_x(), $urandom, $urandom);
				send_req(tmp);
				sent++;
			end
			repeat ($urandom_range(1, 6)) begin
				send_req(mk(nbli_pkg::OP_QUERY, $urandom, $urandom, rand_x()));
				sent++;
			end
			sent++;
		end
		req_valid <= 1'b0;

		// Drain: watchdog catches a hang.
		while (interp_expected.size() != 0) @(posedge clk);
		drain = 0;
		while (drain < 200) begin
			@(posedge clk);
			drain++;
		end
		if (err_count == 0) begin
			$display("nearest_bracket_linear_interp_unit regression: pass");
		end else begin
			$display("nearest_bracket_linear_interp_unit regression: fail");
		end
		$finish;
	end

endmodule
